/* rtl/fbcm_pkg.sv */
package fbcm_pkg;

    typedef enum logic [1:0] {
        CMD_SEEK_SET = 2'd0,
        CMD_SEEK_CUR = 2'd1,
        CMD_SEEK_END = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_CMD   = 2'd1,
        STAT_TRUNCATED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_FILE_SIZE   = 2'd0,
        REG_BLOCK_SHIFT = 2'd1,
        REG_SLOT_COUNT  = 2'd2
    } reg_index_t;

    localparam logic [4:0]  SHIFT_MIN       = 5'd4;
    localparam logic [4:0]  SHIFT_MAX       = 5'd20;
    localparam logic [31:0] FILE_SIZE_RESET = 32'd0;
    localparam logic [4:0]  SHIFT_RESET     = 5'd12;
    localparam logic [6:0]  SLOTS_RESET     = 7'd64;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEEK,
        ST_CHECK,
        ST_LOOKUP,
        ST_EVRD,
        ST_EVWR,
        ST_FILL,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic check;
        logic lookup;
        logic ev_latch;
        logic ev_wr;
        logic fill_wr;
        logic emit_chunk;
        logic emit_seek;
        logic emit_empty;
    } dp_cmd_t;

    typedef struct packed {
        logic flush;
        logic clr_done;
        logic is_read;
        logic empty;
        logic hit;
        logic room;
        logic last;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/fbcm_ram.sv */
module fbcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/fbcm_ctrl.sv */
module fbcm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  fbcm_pkg::dp_stat_t st,
    output fbcm_pkg::dp_cmd_t  cmd
);

    fbcm_pkg::state_t state_reg;
    fbcm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fbcm_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            fbcm_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = fbcm_pkg::ST_IDLE;
                end
            end
            fbcm_pkg::ST_IDLE:
            begin
                in_stall = st.flush;
                if (in_valid && !st.flush)
                begin
                    cmd.accept = 1'b1;
                    state_next = st.is_read ? fbcm_pkg::ST_CHECK : fbcm_pkg::ST_SEEK;
                end
            end
            fbcm_pkg::ST_SEEK:
            begin
                if (st.out_free)
                begin
                    cmd.emit_seek = 1'b1;
                    state_next    = fbcm_pkg::ST_IDLE;
                end
            end
            fbcm_pkg::ST_CHECK:
            begin
                if (st.empty)
                begin
                    state_next = fbcm_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd.check  = 1'b1;
                    state_next = fbcm_pkg::ST_LOOKUP;
                end
            end
            fbcm_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                if (st.hit)
                begin
                    state_next = fbcm_pkg::ST_EMIT;
                end
                else if (st.room)
                begin
                    state_next = fbcm_pkg::ST_FILL;
                end
                else
                begin
                    state_next = fbcm_pkg::ST_EVRD;
                end
            end
            fbcm_pkg::ST_EVRD:
            begin
                cmd.ev_latch = 1'b1;
                state_next   = fbcm_pkg::ST_EVWR;
            end
            fbcm_pkg::ST_EVWR:
            begin
                cmd.ev_wr  = 1'b1;
                state_next = fbcm_pkg::ST_FILL;
            end
            fbcm_pkg::ST_FILL:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = fbcm_pkg::ST_EMIT;
            end
            fbcm_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_chunk = 1'b1;
                    state_next     = st.last ? fbcm_pkg::ST_IDLE : fbcm_pkg::ST_CHECK;
                end
            end
            fbcm_pkg::ST_EMPTY:
            begin
                if (st.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = fbcm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fbcm_pkg::ST_CLEAR;
            end
        endcase
        // a register write reopens the file: wipe the map again
        if (st.flush)
        begin
            state_next = fbcm_pkg::ST_CLEAR;
        end
    end

endmodule

/* rtl/fbcm_dp.sv */
module fbcm_dp #(
    parameter int MAX_BLOCKS = 4096,
    parameter int NUM_SLOTS  = 64,
    parameter int MAX_CHUNKS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [1:0]           command,
    input  logic signed [32:0]   seek_offset,
    input  logic [31:0]          read_length,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [31:0]          position,
    output logic [11:0]          block_number,
    output logic [5:0]           slot,
    output logic [19:0]          offset_in_block,
    output logic [20:0]          chunk_length,
    output logic                 fetch_needed,
    output logic                 evict_valid,
    output logic [11:0]          evicted_block,
    output logic                 eof,
    output logic [1:0]           status,
    output logic                 last,
    input  fbcm_pkg::dp_cmd_t    cmd,
    output fbcm_pkg::dp_stat_t   st
);

    localparam int MAP_AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAP_DW  = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int N_W     = $clog2(MAX_CHUNKS + 1);
    localparam int SC_W    = (CNT_W > 7) ? CNT_W : 7;

    // configuration
    logic [31:0] fs_reg;
    logic [4:0]  shift_reg;
    logic [6:0]  slots_reg;

    // state
    logic [31:0]        pos_reg;
    logic [31:0]        len_reg;
    logic [1:0]         cmd_reg;
    logic signed [32:0] off_reg;
    logic [CNT_W-1:0]   filled_reg;
    logic [SLOT_AW-1:0] victim_reg;
    logic [MAP_AW-1:0]  clr_cnt_reg;
    logic [N_W-1:0]     n_reg;

    // per chunk
    logic [MAP_AW-1:0]  blk_reg;
    logic [19:0]        boff_reg;
    logic [20:0]        c_reg;
    logic [SLOT_AW-1:0] slot_reg;
    logic               fetch_reg;
    logic               ev_reg;
    logic [MAP_AW-1:0]  evblk_reg;

    logic               out_valid_reg;
    logic               flush;

    // memories
    logic               map_we;
    logic [MAP_AW-1:0]  map_waddr;
    logic [MAP_DW-1:0]  map_wdata;
    logic [MAP_DW-1:0]  map_rdata;
    logic [MAP_AW-1:0]  owner_rdata;
    logic               owner_re;
    logic [31:0]        cur_blk;
    logic [SLOT_AW-1:0] victim_use;

    fbcm_ram #(.WIDTH(MAP_DW), .DEPTH(MAX_BLOCKS)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (cmd.check),
        .raddr (cur_blk[MAP_AW-1:0]),
        .rdata (map_rdata)
    );

    fbcm_ram #(.WIDTH(MAP_AW), .DEPTH(NUM_SLOTS)) u_owner (
        .clk   (clk),
        .we    (cmd.fill_wr),
        .waddr (slot_reg),
        .wdata (blk_reg),
        .re    (owner_re),
        .raddr (victim_use),
        .rdata (owner_rdata)
    );

    // effective settings
    logic [4:0]       eff_shift;
    logic [CNT_W-1:0] eff_slots;
    logic [SC_W-1:0]  sc_wide;

    always_comb
    begin
        if (shift_reg < fbcm_pkg::SHIFT_MIN)
        begin
            eff_shift = fbcm_pkg::SHIFT_MIN;
        end
        else if (shift_reg > fbcm_pkg::SHIFT_MAX)
        begin
            eff_shift = fbcm_pkg::SHIFT_MAX;
        end
        else
        begin
            eff_shift = shift_reg;
        end
        sc_wide = SC_W'(slots_reg);
        if (sc_wide == '0)
        begin
            eff_slots = CNT_W'(1);
        end
        else if (sc_wide > SC_W'(NUM_SLOTS))
        begin
            eff_slots = CNT_W'(NUM_SLOTS);
        end
        else
        begin
            eff_slots = CNT_W'(sc_wide);
        end
    end

    // chunk geometry from the current position
    logic [31:0] blk_mask;
    logic [20:0] blk_size;
    logic [20:0] room_in_blk;
    logic [20:0] cur_c;

    always_comb
    begin
        cur_blk     = pos_reg >> eff_shift;
        blk_mask    = (32'd1 << eff_shift) - 32'd1;
        blk_size    = 21'd1 << eff_shift;
        room_in_blk = blk_size - 21'(pos_reg & blk_mask);
        cur_c       = (32'(room_in_blk) > len_reg) ? len_reg[20:0] : room_in_blk;
    end

    // seek target
    logic signed [33:0] base;
    logic signed [33:0] target;
    logic               seek_ge;
    logic [31:0]        seek_pos;

    always_comb
    begin
        case (cmd_reg)
            fbcm_pkg::CMD_SEEK_CUR: base = $signed({2'b00, pos_reg});
            fbcm_pkg::CMD_SEEK_END: base = $signed({2'b00, fs_reg});
            default:                base = '0;
        endcase
        target = base + 34'(off_reg);
        if (target[33])
        begin
            seek_ge = (fs_reg == 32'd0);
        end
        else
        begin
            seek_ge = target[32:0] >= {1'b0, fs_reg};
        end
        if (seek_ge)
        begin
            seek_pos = fs_reg;
        end
        else if (target[33])
        begin
            seek_pos = 32'd0;
        end
        else
        begin
            seek_pos = target[31:0];
        end
    end

    // replacement choice
    logic               map_hit;
    logic               has_room;

    always_comb
    begin
        map_hit    = map_rdata != '0;
        has_room   = filled_reg < eff_slots;
        victim_use = (CNT_W'(victim_reg) >= eff_slots) ? '0 : victim_reg;
        owner_re   = cmd.lookup && !map_hit && !has_room;
    end

    logic [31:0] len_left;
    logic [31:0] pos_after;
    logic        chunk_last;
    logic [31:0] clip_len;

    always_comb
    begin
        len_left   = len_reg - 32'(c_reg);
        pos_after  = pos_reg + 32'(c_reg);
        chunk_last = (len_left == 32'd0) || (n_reg == N_W'(MAX_CHUNKS - 1))
                     || (blk_reg == MAP_AW'(MAX_BLOCKS - 1));
        clip_len   = (read_length > fs_reg - pos_reg) ? fs_reg - pos_reg : read_length;
    end

    // map write port: clearing pass, eviction, fill
    always_comb
    begin
        map_we    = cmd.clr_step || cmd.ev_wr || cmd.fill_wr;
        map_waddr = clr_cnt_reg;
        map_wdata = '0;
        if (cmd.ev_wr)
        begin
            map_waddr = evblk_reg;
        end
        else if (cmd.fill_wr)
        begin
            map_waddr = blk_reg;
            map_wdata = MAP_DW'(slot_reg) + MAP_DW'(1);
        end
    end

    assign flush = cfg_we && ((cfg_index == fbcm_pkg::REG_FILE_SIZE)
                   || (cfg_index == fbcm_pkg::REG_BLOCK_SHIFT)
                   || (cfg_index == fbcm_pkg::REG_SLOT_COUNT));

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        st.flush    = flush;
        st.clr_done = clr_cnt_reg == MAP_AW'(MAX_BLOCKS - 1);
        st.is_read  = command == fbcm_pkg::CMD_READ;
        st.empty    = (len_reg == 32'd0) || (cur_blk >= 32'(MAX_BLOCKS));
        st.hit      = map_hit;
        st.room     = has_room;
        st.last     = chunk_last;
        st.out_free = out_free;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg        <= fbcm_pkg::FILE_SIZE_RESET;
            shift_reg     <= fbcm_pkg::SHIFT_RESET;
            slots_reg     <= fbcm_pkg::SLOTS_RESET;
            pos_reg       <= '0;
            filled_reg    <= '0;
            victim_reg    <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (flush)
            begin
                case (cfg_index)
                    fbcm_pkg::REG_FILE_SIZE:   fs_reg    <= cfg_data;
                    fbcm_pkg::REG_BLOCK_SHIFT: shift_reg <= cfg_data[4:0];
                    default:                   slots_reg <= cfg_data[6:0];
                endcase
                pos_reg     <= '0;
                filled_reg  <= '0;
                victim_reg  <= '0;
                clr_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.clr_step)
                begin
                    clr_cnt_reg <= clr_cnt_reg + MAP_AW'(1);
                end
                if (cmd.lookup && !map_hit)
                begin
                    if (has_room)
                    begin
                        filled_reg <= filled_reg + CNT_W'(1);
                    end
                    else
                    begin
                        victim_reg <= (CNT_W'(victim_use) + CNT_W'(1) >= eff_slots)
                                      ? '0 : victim_use + SLOT_AW'(1);
                    end
                end
                if (cmd.emit_seek)
                begin
                    pos_reg <= seek_pos;
                end
                if (cmd.emit_chunk)
                begin
                    pos_reg <= pos_after;
                end
            end
            if (cmd.emit_seek || cmd.emit_chunk || cmd.emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and chunk payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg <= command;
            off_reg <= seek_offset;
            len_reg <= clip_len;
            n_reg   <= '0;
        end
        if (cmd.emit_chunk)
        begin
            len_reg <= len_left;
            n_reg   <= n_reg + N_W'(1);
        end
        if (cmd.check)
        begin
            blk_reg  <= cur_blk[MAP_AW-1:0];
            boff_reg <= 20'(pos_reg & blk_mask);
            c_reg    <= cur_c;
        end
        if (cmd.lookup)
        begin
            evblk_reg <= '0;
            if (map_hit)
            begin
                slot_reg  <= SLOT_AW'(map_rdata - MAP_DW'(1));
                fetch_reg <= 1'b0;
                ev_reg    <= 1'b0;
            end
            else if (has_room)
            begin
                slot_reg  <= SLOT_AW'(filled_reg);
                fetch_reg <= 1'b1;
                ev_reg    <= 1'b0;
            end
            else
            begin
                slot_reg  <= victim_use;
                fetch_reg <= 1'b1;
                ev_reg    <= 1'b1;
            end
        end
        if (cmd.ev_latch)
        begin
            evblk_reg <= owner_rdata;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (cmd.emit_seek || cmd.emit_empty)
        begin
            block_number    <= '0;
            slot            <= '0;
            offset_in_block <= '0;
            chunk_length    <= '0;
            fetch_needed    <= 1'b0;
            evict_valid     <= 1'b0;
            evicted_block   <= '0;
            last            <= 1'b1;
            if (cmd.emit_seek)
            begin
                position <= seek_pos;
                eof      <= seek_ge;
                status   <= fbcm_pkg::STAT_OK;
            end
            else
            begin
                position <= pos_reg;
                eof      <= pos_reg >= fs_reg;
                status   <= (len_reg != 32'd0) ? fbcm_pkg::STAT_TRUNCATED : fbcm_pkg::STAT_OK;
            end
        end
        else if (cmd.emit_chunk)
        begin
            position        <= pos_after;
            block_number    <= 12'(blk_reg);
            slot            <= 6'(slot_reg);
            offset_in_block <= boff_reg;
            chunk_length    <= c_reg;
            fetch_needed    <= fetch_reg;
            evict_valid     <= ev_reg;
            evicted_block   <= 12'(evblk_reg);
            eof             <= pos_after >= fs_reg;
            last            <= chunk_last;
            status          <= (chunk_last && len_left != 32'd0)
                               ? fbcm_pkg::STAT_TRUNCATED : fbcm_pkg::STAT_OK;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/file_block_cache_mapper.sv */
// channel  direction  handshake            word
// in       input      in_valid / in_stall  command, seek_offset, read_length
// out      output     out_valid/out_stall  position .. last, one word per seek, chunk or empty read
// cfg      input      cfg_we               cfg_index, cfg_data (write only)
//
// a seek passes SEEK; a read passes per chunk CHECK, LOOKUP, then EMIT on a hit,
// FILL, EMIT on a fill into a free slot and EVRD, EVWR, FILL, EMIT when a slot is
// reused (map ram has one write port, so eviction and fill are written in separate
// cycles); an empty read passes CHECK, EMPTY; after reset and after every register
// write the block map is cleared one entry a cycle with in_stall high
// a stalled output holds the word; the datapath waits in place behind it
module file_block_cache_mapper #(
    parameter int MAX_BLOCKS = 4096,
    parameter int NUM_SLOTS  = 64,
    parameter int MAX_CHUNKS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic signed [32:0] seek_offset,
    input  logic [31:0]        read_length,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        position,
    output logic [11:0]        block_number,
    output logic [5:0]         slot,
    output logic [19:0]        offset_in_block,
    output logic [20:0]        chunk_length,
    output logic               fetch_needed,
    output logic               evict_valid,
    output logic [11:0]        evicted_block,
    output logic               eof,
    output logic [1:0]         status,
    output logic               last
);

    fbcm_pkg::dp_cmd_t  cmd;
    fbcm_pkg::dp_stat_t st;

    fbcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    fbcm_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .NUM_SLOTS  (NUM_SLOTS),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .command         (command),
        .seek_offset     (seek_offset),
        .read_length     (read_length),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .position        (position),
        .block_number    (block_number),
        .slot            (slot),
        .offset_in_block (offset_in_block),
        .chunk_length    (chunk_length),
        .fetch_needed    (fetch_needed),
        .evict_valid     (evict_valid),
        .evicted_block   (evicted_block),
        .eof             (eof),
        .status          (status),
        .last            (last),
        .cmd             (cmd),
        .st              (st)
    );

endmodule

/* rtl/fbcm_checker.sv */
module fbcm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] position,
    input logic [20:0] chunk_length,
    input logic        fetch_needed,
    input logic        evict_valid,
    input logic [11:0] evicted_block,
    input logic [1:0]  status,
    input logic        last
);

    // stalled word must hold
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position) && $stable(last))
        else $error("output word changed while stalled");

    a_evict_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evict_valid |-> fetch_needed)
        else $error("eviction without fetch");

    a_evblk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evict_valid |-> evicted_block == 12'd0)
        else $error("evicted block set without eviction");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chunk_length == 21'd0 |-> last && !fetch_needed)
        else $error("empty word not final");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == fbcm_pkg::STAT_TRUNCATED |-> last)
        else $error("truncation flagged before final word");

endmodule

bind file_block_cache_mapper fbcm_checker u_fbcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .position      (position),
    .chunk_length  (chunk_length),
    .fetch_needed  (fetch_needed),
    .evict_valid   (evict_valid),
    .evicted_block (evicted_block),
    .status        (status),
    .last          (last)
);

/* bench/file_block_cache_mapper_tb.sv */
`timescale 1ns / 1ps

module file_block_cache_mapper_tb;

    localparam int MAP_DEPTH  = 4096;
    localparam int SLOT_DEPTH = 64;
    localparam int CHUNK_MAX  = 64;

    typedef struct packed {
        fbcm_pkg::cmd_t     cmd;
        logic signed [32:0] offs;
        logic [31:0]        len;
    } request_t;

    typedef struct packed {
        logic [31:0]       pos;
        logic [11:0]       blk;
        logic [5:0]        slt;
        logic [19:0]       boff;
        logic [20:0]       clen;
        logic              fetch;
        logic              ev;
        logic [11:0]       evblk;
        logic              at_eof;
        fbcm_pkg::status_t st;
        logic              fin;
    } chunk_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] command = 2'd0;
    logic signed [32:0] seek_offset = 33'sd0;
    logic [31:0] read_length = 32'd0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] position;
    logic [11:0] block_number;
    logic [5:0] slot;
    logic [19:0] offset_in_block;
    logic [20:0] chunk_length;
    logic fetch_needed, evict_valid, eof, last;
    logic [11:0] evicted_block;
    logic [1:0] status;

    file_block_cache_mapper dut (.*);

    always #6 clk = ~clk;

    // shadow of the mapper state and registers
    logic [31:0] m_file_size;
    logic [4:0]  m_shift;
    logic [6:0]  m_slots;
    logic [31:0] m_pos;
    logic        m_eof;
    logic [6:0]  m_map [MAP_DEPTH];
    logic [11:0] m_owner [SLOT_DEPTH];
    int unsigned m_filled, m_victim;

    request_t    pending [$];
    chunk_word_t expected_words [$];
    request_t    offered;
    int unsigned accepted = 0;
    int unsigned errors = 0;
    logic        rx_hold = 1'b0;
    logic        calm;

    assign calm = (accepted >= 150) && (accepted < 230);

    function automatic void reopen_file();
        foreach (m_map[i]) m_map[i] = '0;
        m_filled = 0;
        m_victim = 0;
        m_pos = '0;
        m_eof = 1'b0;
    endfunction

    function automatic void predict_request(request_t rq);
        longint fs, pos, target, len, bs, blk, boff, c;
        int unsigned sh, ns, n, slt;
        chunk_word_t w;
        fs = longint'(m_file_size);
        pos = longint'(m_pos);
        if (pos > fs) pos = fs;
        if (rq.cmd != fbcm_pkg::CMD_READ)
        begin
            target = longint'(rq.offs);
            if (rq.cmd == fbcm_pkg::CMD_SEEK_CUR) target += pos;
            else if (rq.cmd == fbcm_pkg::CMD_SEEK_END) target += fs;
            if (target < 0) target = 0;
            if (target >= fs)
            begin
                pos = fs;
                m_eof = 1'b1;
            end
            else
            begin
                pos = target;
                m_eof = 1'b0;
            end
            m_pos = pos[31:0];
            w = '0;
            w.pos = pos[31:0];
            w.at_eof = m_eof;
            w.st = fbcm_pkg::STAT_OK;
            w.fin = 1'b1;
            expected_words.push_back(w);
            return;
        end
        sh = (m_shift < fbcm_pkg::SHIFT_MIN) ? fbcm_pkg::SHIFT_MIN
           : (m_shift > fbcm_pkg::SHIFT_MAX) ? fbcm_pkg::SHIFT_MAX : m_shift;
        ns = (m_slots == 0) ? 1 : (m_slots > SLOT_DEPTH) ? SLOT_DEPTH : m_slots;
        bs = longint'(1) << sh;
        len = longint'(rq.len);
        if (len > fs - pos) len = fs - pos;
        n = 0;
        while (len > 0 && n < CHUNK_MAX)
        begin
            blk = pos >> sh;
            if (blk >= MAP_DEPTH) break;
            boff = pos & (bs - 1);
            c = bs - boff;
            if (c > len) c = len;
            w = '0;
            if (m_map[blk] != 0)
            begin
                slt = m_map[blk] - 1;
            end
            else
            begin
                w.fetch = 1'b1;
                if (m_filled < ns)
                begin
                    slt = m_filled;
                    m_filled++;
                end
                else
                begin
                    if (m_victim >= ns) m_victim = 0;
                    slt = m_victim;
                    w.ev = 1'b1;
                    w.evblk = m_owner[slt];
                    m_map[m_owner[slt]] = '0;
                    m_victim = (m_victim + 1 >= ns) ? 0 : m_victim + 1;
                end
                m_map[blk] = 7'(slt + 1);
                m_owner[slt] = blk[11:0];
            end
            pos += c;
            len -= c;
            w.pos = pos[31:0];
            w.blk = blk[11:0];
            w.slt = slt[5:0];
            w.boff = boff[19:0];
            w.clen = c[20:0];
            w.at_eof = (pos >= fs);
            w.st = fbcm_pkg::STAT_OK;
            expected_words.push_back(w);
            n++;
        end
        m_pos = pos[31:0];
        m_eof = (pos >= fs);
        if (n == 0)
        begin
            w = '0;
            w.pos = pos[31:0];
            w.at_eof = m_eof;
            expected_words.push_back(w);
        end
        w = expected_words.pop_back();
        w.st = (len > 0) ? fbcm_pkg::STAT_TRUNCATED : fbcm_pkg::STAT_OK;
        w.fin = 1'b1;
        expected_words.push_back(w);
    endfunction

    // driver
    always @(posedge clk)
    begin
        request_t rq;
        logic go;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_request(offered);
                accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                go = (pending.size() > 0) && (calm || $urandom_range(0, 99) >= 17);
                if (go)
                begin
                    rq = pending.pop_front();
                    offered = rq;
                    in_valid <= 1'b1;
                    command <= rq.cmd;
                    seek_offset <= rq.offs;
                    read_length <= rq.len;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        chunk_word_t got, want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {position, block_number, slot, offset_in_block, chunk_length,
                       fetch_needed, evict_valid, evicted_block, eof,
                       fbcm_pkg::status_t'(status), last};
                if (expected_words.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected word %p", got);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            out_stall <= rx_hold || (!calm && $urandom_range(0, 99) < 17);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        wait (accepted >= 60);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (600) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic write_reg(fbcm_pkg::reg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            fbcm_pkg::REG_FILE_SIZE:   m_file_size = value;
            fbcm_pkg::REG_BLOCK_SHIFT: m_shift = value[4:0];
            default:                   m_slots = value[6:0];
        endcase
        reopen_file();
    endtask

    task automatic wait_drained();
        wait (pending.size() == 0 && !in_valid && expected_words.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic add_request(fbcm_pkg::cmd_t c, logic signed [32:0] o, logic [31:0] l);
        request_t rq;
        rq.cmd = c;
        rq.offs = o;
        rq.len = l;
        pending.push_back(rq);
    endtask

    task automatic add_random(int count);
        int unsigned fs, bs, sel;
        logic signed [32:0] o;
        logic [31:0] l;
        fs = m_file_size;
        bs = 1 << ((m_shift < fbcm_pkg::SHIFT_MIN) ? fbcm_pkg::SHIFT_MIN
                 : (m_shift > fbcm_pkg::SHIFT_MAX) ? fbcm_pkg::SHIFT_MAX : m_shift);
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            o = {1'($urandom_range(0, 1)), $urandom()};
            l = $urandom();
            if (sel < 55)
            begin
                if ($urandom_range(0, 9) != 0) l = $urandom_range(0, 3 * bs);
                add_request(fbcm_pkg::CMD_READ, o, l);
            end
            else if (sel < 70)
            begin
                if ($urandom_range(0, 3) != 0) o = 33'($urandom_range(0, fs));
                add_request(fbcm_pkg::CMD_SEEK_SET, o, l);
            end
            else if (sel < 88)
            begin
                if ($urandom_range(0, 3) != 0)
                    o = 33'(longint'($urandom_range(0, 8 * bs)) - 4 * bs);
                add_request(fbcm_pkg::CMD_SEEK_CUR, o, l);
            end
            else
            begin
                if ($urandom_range(0, 3) != 0) o = -33'($urandom_range(0, 4 * bs));
                add_request(fbcm_pkg::CMD_SEEK_END, o, l);
            end
        end
    endtask

    initial
    begin
        m_file_size = fbcm_pkg::FILE_SIZE_RESET;
        m_shift = fbcm_pkg::SHIFT_RESET;
        m_slots = fbcm_pkg::SLOTS_RESET;
        foreach (m_owner[i]) m_owner[i] = '0;
        reopen_file();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty file straight after reset
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'hFFFF_FFFF);
        add_request(fbcm_pkg::CMD_SEEK_SET, 33'sd5, 32'd0);
        add_request(fbcm_pkg::CMD_SEEK_END, -33'sd1, 32'd0);
        wait_drained();

        // tiny blocks, three slots, so evictions come early
        write_reg(fbcm_pkg::REG_FILE_SIZE, 32'd10000);
        write_reg(fbcm_pkg::REG_BLOCK_SHIFT, 32'd2);
        write_reg(fbcm_pkg::REG_SLOT_COUNT, 32'd3);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'd100);
        add_request(fbcm_pkg::CMD_SEEK_CUR, -33'sd5, 32'd0);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'd40);
        add_request(fbcm_pkg::CMD_SEEK_SET, 33'sd3, 32'd0);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'd0);
        add_request(fbcm_pkg::CMD_SEEK_END, 33'sd5, 32'd0);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'd16);
        add_request(fbcm_pkg::CMD_SEEK_SET, {1'b1, 32'd0}, 32'd0);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'hFFFF_FFFF);
        add_request(fbcm_pkg::CMD_SEEK_CUR, {1'b0, 32'hFFFF_FFFF}, 32'd0);
        add_request(fbcm_pkg::CMD_SEEK_SET, {1'b1, 32'hFFFF_FFFF}, 32'd0);
        add_request(fbcm_pkg::CMD_SEEK_SET, 33'sd9999, 32'd0);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'd5);
        wait_drained();

        // largest file, smallest blocks: reads run past the block map
        write_reg(fbcm_pkg::REG_FILE_SIZE, 32'hFFFF_FFFF);
        write_reg(fbcm_pkg::REG_SLOT_COUNT, 32'd0);
        add_request(fbcm_pkg::CMD_SEEK_SET, 33'sd65536, 32'd0);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'd64);
        add_request(fbcm_pkg::CMD_SEEK_SET, 33'sd65520, 32'd0);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'd100);
        add_request(fbcm_pkg::CMD_SEEK_END, 33'sd0, 32'd0);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'd1);
        add_request(fbcm_pkg::CMD_SEEK_SET, 33'sd0, 32'd0);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'd48);
        add_request(fbcm_pkg::CMD_READ, 33'sd0, 32'd48);
        wait_drained();

        write_reg(fbcm_pkg::REG_BLOCK_SHIFT, 32'd31);
        write_reg(fbcm_pkg::REG_SLOT_COUNT, 32'd127);
        add_random(55);
        wait_drained();

        write_reg(fbcm_pkg::REG_FILE_SIZE, 32'd5000);
        write_reg(fbcm_pkg::REG_BLOCK_SHIFT, 32'd4);
        write_reg(fbcm_pkg::REG_SLOT_COUNT, 32'd1);
        add_random(60);
        wait_drained();

        write_reg(fbcm_pkg::REG_FILE_SIZE, 32'd70000);
        write_reg(fbcm_pkg::REG_BLOCK_SHIFT, 32'd8);
        write_reg(fbcm_pkg::REG_SLOT_COUNT, 32'd64);
        add_random(70);
        wait_drained();

        write_reg(fbcm_pkg::REG_FILE_SIZE, 32'h0010_0007);
        write_reg(fbcm_pkg::REG_BLOCK_SHIFT, 32'd20);
        write_reg(fbcm_pkg::REG_SLOT_COUNT, 32'd2);
        add_random(50);
        wait_drained();

        write_reg(fbcm_pkg::REG_FILE_SIZE, 32'd3000);
        write_reg(fbcm_pkg::REG_BLOCK_SHIFT, 32'd5);
        write_reg(fbcm_pkg::REG_SLOT_COUNT, 32'd5);
        add_random(55);
        wait_drained();

        write_reg(fbcm_pkg::REG_FILE_SIZE, $urandom_range(1, 200000));
        write_reg(fbcm_pkg::REG_BLOCK_SHIFT, $urandom_range(4, 12));
        write_reg(fbcm_pkg::REG_SLOT_COUNT, $urandom_range(1, 64));
        add_random(50);
        wait_drained();

        repeat (50) @(posedge clk);
        errors += expected_words.size();
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* file_block_cache_mapper.f */
rtl/fbcm_pkg.sv
rtl/fbcm_ram.sv
rtl/fbcm_ctrl.sv
rtl/fbcm_dp.sv
rtl/file_block_cache_mapper.sv
rtl/fbcm_checker.sv
bench/file_block_cache_mapper_tb.sv
